// ----- rtl/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle, held off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Condition must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed");

`endif

// ----- rtl/mdq_pkg.sv -----
package mdq_pkg;

	// Command codes of an input transaction
	typedef enum logic [1:0] {
		CMD_PUSH = 2'd0,
		CMD_POP  = 2'd1,
		CMD_PEEK = 2'd2,
		CMD_NONE = 2'd3
	} cmd_e_t;

	// Byte returned by pop or peek of an empty queue
	localparam logic [7:0] EMPTY_MARK = 8'd35;

	// Classified operation passed from front to back
	typedef struct packed {
		cmd_e_t      cmd;
		logic [6:0]  qidx;
		logic        side;
		logic [7:0]  value;
		logic        oor;    // queue index beyond the bank
	} op_t;

	// Queue status seen by both ends
	typedef struct packed {
		logic full;
		logic avail;
	} fifo_stat_t;

	// Back-end status seen by the front
	typedef struct packed {
		logic clearing;
	} back_stat_t;

endpackage

// ----- rtl/mdq_front.sv -----
module mdq_front import mdq_pkg::*; #(
	parameter int NUM_QUEUES = 128
) (
	input  logic       start,
	input  logic [1:0] command,
	input  logic [6:0] queue_index,
	input  logic       side,
	input  logic [7:0] value,
	input  fifo_stat_t fifo_stat,
	input  back_stat_t back_stat,
	output logic       busy,
	output logic       push,
	output op_t        item
);

	cmd_e_t cmd;

	assign cmd  = cmd_e_t'(command);

	// hold off while the queue is full or the pointer table is being cleared
	assign busy = fifo_stat.full | back_stat.clearing;

	// unused command code is taken and discarded here
	assign push = start & ~busy & (cmd != CMD_NONE);

	// classify the transaction
	always_comb begin
		item.cmd   = cmd;
		item.qidx  = queue_index;
		item.side  = side;
		item.value = value;
		item.oor   = (int'(queue_index) >= NUM_QUEUES);
	end

endmodule

// ----- rtl/mdq_fifo.sv -----
module mdq_fifo import mdq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  op_t        push_item,
	input  logic       pop,
	output op_t        head_item,
	output fifo_stat_t stat
);

	op_t        ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign head_item  = ent_q[rd_ptr_q];
	assign stat.full  = (cnt_q == 2'd2);
	assign stat.avail = (cnt_q != 2'd0);

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/mdq_back.sv -----
module mdq_back import mdq_pkg::*; #(
	parameter int NUM_QUEUES  = 128,
	parameter int QUEUE_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  op_t        head_item,
	input  fifo_stat_t fifo_stat,
	output logic       pop,
	output back_stat_t stat,
	output logic       result_valid,
	output logic [7:0] result_byte,
	output logic       was_empty,
	output logic       dropped
);

	localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PW    = $clog2(QUEUE_DEPTH);
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int SLOTS = NUM_QUEUES * QUEUE_DEPTH;
	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_EXEC  = 4'b0100,
		S_OUT   = 4'b1000
	} state_t;

	state_t state_q;

	// pointer table and byte store
	logic [PW-1:0] head_mem [NUM_QUEUES];
	logic [CW-1:0] cnt_mem  [NUM_QUEUES];
	logic [7:0]    byte_mem [SLOTS];

	logic [QW-1:0] clr_cnt_q;
	op_t           item_q;
	logic [PW-1:0] head_rd_q;
	logic [CW-1:0] cnt_rd_q;
	logic [7:0]    byte_rd_q;

	logic          res_valid_q;
	logic [7:0]    res_byte_q;
	logic          res_empty_q;
	logic          res_drop_q;

	logic [QW-1:0] q_head;
	logic [QW-1:0] q_cur;
	logic [QW-1:0] ptr_rd_addr;
	logic [QW-1:0] ptr_wr_addr;
	logic          ptr_we;
	logic [PW-1:0] head_wr;
	logic [CW-1:0] cnt_wr;

	logic          is_full;
	logic          is_empty;
	logic [CW-1:0] off;
	logic [CW:0]   sum;
	logic [PW-1:0] pos_add;
	logic [PW-1:0] pos_dec;
	logic [PW-1:0] pos_inc;
	logic [PW-1:0] pos;
	logic [AW-1:0] byte_addr;
	logic          byte_we;

	assign q_head = QW'(head_item.qidx);
	assign q_cur  = QW'(item_q.qidx);

	assign stat.clearing = (state_q == S_CLEAR);
	assign pop           = (state_q == S_IDLE) & fifo_stat.avail;

	// ring arithmetic on the fetched pointers
	assign is_full  = (cnt_rd_q == CW'(QUEUE_DEPTH));
	assign is_empty = (cnt_rd_q == '0);
	assign off      = (item_q.cmd == CMD_PUSH) ? cnt_rd_q : cnt_rd_q - CW'(1);
	assign sum      = (CW+1)'(head_rd_q) + (CW+1)'(off);
	assign pos_add  = (sum >= (CW+1)'(QUEUE_DEPTH)) ?
		PW'(sum - (CW+1)'(QUEUE_DEPTH)) : PW'(sum);
	assign pos_dec  = (head_rd_q == '0) ? PW'(QUEUE_DEPTH - 1) : head_rd_q - PW'(1);
	assign pos_inc  = (head_rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_rd_q + PW'(1);

	// slot choice and pointer update for the current operation
	always_comb begin
		pos     = head_rd_q;
		head_wr = head_rd_q;
		cnt_wr  = cnt_rd_q;
		ptr_we  = 1'b0;
		byte_we = 1'b0;
		case (item_q.cmd)
			CMD_PUSH: begin
				pos     = item_q.side ? pos_add : pos_dec;
				head_wr = item_q.side ? head_rd_q : pos_dec;
				cnt_wr  = cnt_rd_q + CW'(1);
				ptr_we  = (state_q == S_EXEC) & ~is_full;
				byte_we = (state_q == S_EXEC) & ~is_full;
			end
			CMD_POP: begin
				pos     = item_q.side ? pos_add : head_rd_q;
				head_wr = item_q.side ? head_rd_q : pos_inc;
				cnt_wr  = cnt_rd_q - CW'(1);
				ptr_we  = (state_q == S_EXEC) & ~is_empty;
			end
			CMD_PEEK: begin
				pos     = item_q.side ? pos_add : head_rd_q;
			end
			default: begin
				pos     = head_rd_q;
			end
		endcase
	end

	assign byte_addr   = AW'(q_cur) * AW'(QUEUE_DEPTH) + AW'(pos);
	assign ptr_rd_addr = q_head;
	assign ptr_wr_addr = stat.clearing ? clr_cnt_q : q_cur;

	// pointer table: clearing pass writes zeros, execution writes updates
	always_ff @(posedge clk) begin
		if (stat.clearing) begin
			head_mem[ptr_wr_addr] <= '0;
			cnt_mem[ptr_wr_addr]  <= '0;
		end else if (ptr_we) begin
			head_mem[ptr_wr_addr] <= head_wr;
			cnt_mem[ptr_wr_addr]  <= cnt_wr;
		end
		head_rd_q <= head_mem[ptr_rd_addr];
		cnt_rd_q  <= cnt_mem[ptr_rd_addr];
	end

	// byte store
	always_ff @(posedge clk) begin
		if (byte_we) begin
			byte_mem[byte_addr] <= item_q.value;
		end
		byte_rd_q <= byte_mem[byte_addr];
	end

	// operation latch
	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head_item;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == S_OUT) begin
			res_byte_q  <= byte_rd_q;
			res_empty_q <= 1'b0;
			res_drop_q  <= 1'b0;
		end else if (state_q == S_EXEC) begin
			res_byte_q  <= (item_q.cmd == CMD_PUSH) ? 8'd0 : EMPTY_MARK;
			res_empty_q <= (item_q.cmd != CMD_PUSH);
			res_drop_q  <= (item_q.cmd == CMD_PUSH);
		end else begin
			res_byte_q  <= (head_item.cmd == CMD_PUSH) ? 8'd0 : EMPTY_MARK;
			res_empty_q <= (head_item.cmd != CMD_PUSH);
			res_drop_q  <= (head_item.cmd == CMD_PUSH);
		end
	end

	// sequencer and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + QW'(1);
					if (clr_cnt_q == QW'(NUM_QUEUES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (pop) begin
						if (head_item.oor) begin
							res_valid_q <= 1'b1;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					if (item_q.cmd == CMD_PUSH) begin
						res_valid_q <= is_full;
					end else if (is_empty) begin
						res_valid_q <= 1'b1;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					res_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result_byte  = res_byte_q;
	assign was_empty    = res_empty_q;
	assign dropped      = res_drop_q;

endmodule

// ----- rtl/multi_deque_char_engine_core.sv -----
// Flow: a started transaction passes a two-entry queue to the back end; an out-of-range
// queue is reported straight from S_IDLE, other operations read the pointer table and go
// to S_EXEC, where a dropped push or an empty pop/peek ends; a pop/peek that returns
// a byte reads the byte store and strobes from S_OUT. The back end runs one operation at a time.
// Reset: asynchronous, active low; after release a clearing pass zeroes the pointer table
// while busy is high. Results cannot be stalled by the receiver.
module multi_deque_char_engine_core import mdq_pkg::*; #(
	parameter int NUM_QUEUES  = 128,
	parameter int QUEUE_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] command,
	input  logic [6:0] queue_index,
	input  logic       side,
	input  logic [7:0] value,
	output logic       result_valid,
	output logic [7:0] result_byte,
	output logic       was_empty,
	output logic       dropped
);

	op_t        push_item;
	op_t        head_item;
	logic       push;
	logic       pop;
	fifo_stat_t fifo_stat;
	back_stat_t back_stat;

	// accept and classify
	mdq_front #(
		.NUM_QUEUES (NUM_QUEUES)
	) u_front (
		.start       (start),
		.command     (command),
		.queue_index (queue_index),
		.side        (side),
		.value       (value),
		.fifo_stat   (fifo_stat),
		.back_stat   (back_stat),
		.busy        (busy),
		.push        (push),
		.item        (push_item)
	);

	// decoupling queue
	mdq_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.stat      (fifo_stat)
	);

	// execute against pointer table and byte store
	mdq_back #(
		.NUM_QUEUES  (NUM_QUEUES),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_item    (head_item),
		.fifo_stat    (fifo_stat),
		.pop          (pop),
		.stat         (back_stat),
		.result_valid (result_valid),
		.result_byte  (result_byte),
		.was_empty    (was_empty),
		.dropped      (dropped)
	);

endmodule

// ----- rtl/mdq_checker.sv -----
`include "assert_macros.svh"

module mdq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic [7:0] result_byte,
	input logic       was_empty,
	input logic       dropped
);

	// a result is never both an empty report and a dropped push
	`ASSERT_NEVER(a_flags_excl, clk, arst_n, result_valid && was_empty && dropped)

	// empty report carries the empty mark
	`ASSERT_IMPLY(a_empty_mark, clk, arst_n, result_valid && was_empty, result_byte == 8'd35)

	// dropped push carries a zero byte
	`ASSERT_IMPLY(a_drop_zero, clk, arst_n, result_valid && dropped, result_byte == 8'd0)

endmodule

bind multi_deque_char_engine_core mdq_checker u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_byte  (result_byte),
	.was_empty    (was_empty),
	.dropped      (dropped)
);
